// ===== sv/bedm_pkg.sv =====
// Shared types, constants and helpers for the bitap edit distance matcher.
// Used by every module of the block; depends on nothing else.
package bedm_pkg;

    localparam int BEDM_VW     = 64;   // bits per level vector
    localparam int BEDM_ML     = 8;    // highest error level held in hardware
    localparam int BEDM_CFG_W  = 64;   // configuration data width
    localparam int BEDM_IDX_W  = 3;    // configuration register index width
    localparam int BEDM_LEN_W  = 7;    // guide_length register width
    localparam int BEDM_ERR_W  = 4;    // max_errors register width
    localparam int BEDM_CODE_W = 3;    // base_code width
    localparam int BEDM_DIST_W = 4;    // best_distance width
    localparam int BEDM_LIM_W  = $clog2(BEDM_ML + 1);
    localparam int BEDM_QD     = 4;    // depth of the queue between front and back
    localparam int BEDM_QPW    = $clog2(BEDM_QD);
    localparam int BEDM_QCW    = $clog2(BEDM_QD + 1);

    localparam logic [BEDM_IDX_W-1:0] REG_MASK_A     = 3'd0;
    localparam logic [BEDM_IDX_W-1:0] REG_MASK_C     = 3'd1;
    localparam logic [BEDM_IDX_W-1:0] REG_MASK_G     = 3'd2;
    localparam logic [BEDM_IDX_W-1:0] REG_MASK_T     = 3'd3;
    localparam logic [BEDM_IDX_W-1:0] REG_GUIDE_LEN  = 3'd4;
    localparam logic [BEDM_IDX_W-1:0] REG_MAX_ERRORS = 3'd5;

    localparam logic [BEDM_CODE_W-1:0] BASE_A = 3'd0;
    localparam logic [BEDM_CODE_W-1:0] BASE_C = 3'd1;
    localparam logic [BEDM_CODE_W-1:0] BASE_G = 3'd2;
    localparam logic [BEDM_CODE_W-1:0] BASE_T = 3'd3;

    localparam logic [BEDM_LEN_W-1:0] GUIDE_LEN_RESET = 7'd20;

    typedef logic [BEDM_VW-1:0] t_vec;

    typedef struct packed {
        logic                  en;
        logic [BEDM_IDX_W-1:0] idx;
        logic [BEDM_CFG_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Top len bits set, the rest clear. Lengths at or above the width give all ones.
    function automatic t_vec init_vec(input logic [BEDM_LEN_W-1:0] len);
        return ~({BEDM_VW{1'b1}} >> len);
    endfunction

endpackage

// ===== sv/bitap_edit_distance_matcher_top.sv =====
// Bitap edit distance matcher: streams bases against one guide pattern with
// up to min(max_errors, 8) edit differences; reports one result per valid base.
//
// Input channel: drive i_base_code and raise push; the base is transferred at
// a clock edge where push is high and full is low. Codes other than A, C, G, T
// are transferred and dropped without a result.
// Result channel: while empty is low, o_hit and o_best_distance show the oldest
// result; it is transferred at an edge where pop is high.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data; every
// write to a defined register reloads all level vectors. An input base is
// registered in the base queue, then its result in the result buffer; empty
// goes low once that result is stored. One base is processed per cycle while
// the result buffer has room or pops; the limit is the combinational level
// update chain in the back end, which serves one queued base per clock.
// Reset (synchronous, active low) clears both queues, the masks and
// max_errors, and sets guide_length to 20 with the vectors loaded to match.
// If the receiver stops popping, the two-entry result buffer and the
// four-entry base queue fill, then full rises; nothing is lost.
// Depends on bedm_pkg, bedm_front, bedm_queue and bedm_back.
module bitap_edit_distance_matcher_top
    import bedm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [BEDM_IDX_W-1:0]  i_cfg_idx,
    input  logic [BEDM_CFG_W-1:0]  i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [BEDM_CODE_W-1:0] i_base_code,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_hit,
    output logic [BEDM_DIST_W-1:0] o_best_distance
);

    t_cfg_wr cfg;
    t_q_stat q_stat;
    logic    q_push, q_pop;
    t_vec    q_in_mask, q_out_mask;

    assign cfg.en   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    bedm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_base_code (i_base_code),
        .i_q_stat    (q_stat),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_mask    (q_in_mask)
    );

    bedm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_mask),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_data  (q_out_mask)
    );

    bedm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_stat        (q_stat),
        .i_q_mask        (q_out_mask),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_hit           (o_hit),
        .o_best_distance (o_best_distance)
    );

endmodule

// ===== sv/bedm_front.sv =====
// Front end: holds the four base masks, drops symbols that are not a base
// and forwards the selected mask to the work queue. Depends on bedm_pkg.
module bedm_front
    import bedm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg_wr                i_cfg,
    input  logic                   i_push,
    input  logic [BEDM_CODE_W-1:0] i_base_code,
    input  t_q_stat                i_q_stat,
    output logic                   o_full,
    output logic                   o_q_push,
    output t_vec                   o_q_mask
);

    t_vec r_mask_a, r_mask_c, r_mask_g, r_mask_t;
    logic valid_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_a <= '0;
            r_mask_c <= '0;
            r_mask_g <= '0;
            r_mask_t <= '0;
        end else if (i_cfg.en) begin
            case (i_cfg.idx)
                REG_MASK_A: r_mask_a <= i_cfg.data[BEDM_VW-1:0];
                REG_MASK_C: r_mask_c <= i_cfg.data[BEDM_VW-1:0];
                REG_MASK_G: r_mask_g <= i_cfg.data[BEDM_VW-1:0];
                REG_MASK_T: r_mask_t <= i_cfg.data[BEDM_VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        valid_base = 1'b1;
        o_q_mask   = r_mask_a;
        case (i_base_code)
            BASE_A: o_q_mask = r_mask_a;
            BASE_C: o_q_mask = r_mask_c;
            BASE_G: o_q_mask = r_mask_g;
            BASE_T: o_q_mask = r_mask_t;
            default: valid_base = 1'b0;
        endcase
    end

    // Non-base symbols are taken and dropped here; they never reach the back end.
    assign o_full   = i_q_stat.full;
    assign o_q_push = i_push && !i_q_stat.full && valid_base;

endmodule

// ===== sv/bedm_queue.sv =====
// Short queue of pending symbol masks between the front and back ends.
// Depends on bedm_pkg.
module bedm_queue
    import bedm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_vec    i_data,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_vec    o_data
);

    t_vec                 r_mem [BEDM_QD];
    logic [BEDM_QPW-1:0]  r_wp, r_rp;
    logic [BEDM_QCW-1:0]  r_cnt;
    logic                 do_push, do_pop;

    assign o_stat.full  = (r_cnt == BEDM_QCW'(BEDM_QD));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/bedm_back.sv =====
// Back end: level vectors, the per-symbol Wu-Manber update, the hit search
// and a two-entry result buffer. Depends on bedm_pkg.
module bedm_back
    import bedm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg_wr                i_cfg,
    input  t_q_stat                i_q_stat,
    input  t_vec                   i_q_mask,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic                   o_hit,
    output logic [BEDM_DIST_W-1:0] o_best_distance
);

    logic [BEDM_LEN_W-1:0]  r_len, n_len;
    logic [BEDM_ERR_W-1:0]  r_err;
    logic [BEDM_LIM_W-1:0]  lim;
    t_vec                   r_lvl [BEDM_ML+1];
    t_vec                   n_lvl [BEDM_ML+1];
    logic                   cfg_hit;

    logic                   r_res_hit  [2];
    logic [BEDM_DIST_W-1:0] r_res_dist [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   out_room, res_push, res_pop;
    logic                   hit;
    logic [BEDM_DIST_W-1:0] best_dist;

    assign cfg_hit = i_cfg.en && (i_cfg.idx == REG_MASK_A || i_cfg.idx == REG_MASK_C ||
                                  i_cfg.idx == REG_MASK_G || i_cfg.idx == REG_MASK_T ||
                                  i_cfg.idx == REG_GUIDE_LEN || i_cfg.idx == REG_MAX_ERRORS);
    assign n_len = (i_cfg.en && i_cfg.idx == REG_GUIDE_LEN) ?
                   i_cfg.data[BEDM_LEN_W-1:0] : r_len;

    always_comb begin
        if ({1'b0, r_err} > (BEDM_ERR_W+1)'(BEDM_ML)) begin
            lim = BEDM_LIM_W'(BEDM_ML);
        end else begin
            lim = BEDM_LIM_W'(r_err);
        end
    end

    // Each level 1..lim ANDs match, substitution, insertion and deletion terms (level 0
    // is match only, levels above lim hold); deletion uses the new level below, so levels chain.
    always_comb begin
        n_lvl[0] = (r_lvl[0] << 1) | i_q_mask;
        for (int d = 1; d <= BEDM_ML; d++) begin
            if (BEDM_LIM_W'(d) <= lim) begin
                n_lvl[d] = ((r_lvl[d] << 1) | i_q_mask) & (r_lvl[d-1] << 1) &
                           r_lvl[d-1] & (n_lvl[d-1] << 1);
            end else begin
                n_lvl[d] = r_lvl[d];
            end
        end
    end

    // Scan from the top so the lowest hitting level wins.
    always_comb begin
        hit       = 1'b0;
        best_dist = '0;
        for (int d = BEDM_ML; d >= 0; d--) begin
            if (BEDM_LIM_W'(d) <= lim && !n_lvl[d][BEDM_VW-1]) begin
                hit       = 1'b1;
                best_dist = BEDM_DIST_W'(d);
            end
        end
    end

    assign out_room = (r_cnt != 2'd2) || i_pop;
    assign o_q_pop  = !i_q_stat.empty && out_room;
    assign res_push = o_q_pop;
    assign res_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= GUIDE_LEN_RESET;
            r_err <= '0;
            for (int d = 0; d <= BEDM_ML; d++) begin
                r_lvl[d] <= init_vec(GUIDE_LEN_RESET);
            end
        end else begin
            r_len <= n_len;
            if (i_cfg.en && i_cfg.idx == REG_MAX_ERRORS) begin
                r_err <= i_cfg.data[BEDM_ERR_W-1:0];
            end
            if (cfg_hit) begin
                for (int d = 0; d <= BEDM_ML; d++) begin
                    r_lvl[d] <= init_vec(n_len);
                end
            end else if (o_q_pop) begin
                for (int d = 0; d <= BEDM_ML; d++) begin
                    r_lvl[d] <= n_lvl[d];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_hit[r_wp]  <= hit;
            r_res_dist[r_wp] <= best_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (res_push) begin
                r_wp <= !r_wp;
            end
            if (res_pop) begin
                r_rp <= !r_rp;
            end
            if (res_push && !res_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (res_pop && !res_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_empty         = (r_cnt == 2'd0);
    assign o_hit           = r_res_hit[r_rp];
    assign o_best_distance = r_res_dist[r_rp];

`ifndef SYNTHESIS
    a_res_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_dist_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> ({1'b0, best_dist} <= (BEDM_DIST_W+1)'(lim) &&
                      (hit || best_dist == '0)))
        else $error("reported distance beyond the error limit");

    a_cfg_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_lvl[0] == init_vec(r_len) && r_lvl[BEDM_ML] == init_vec(r_len)))
        else $error("level vectors not reinitialized after configuration write");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_pop) |-> !res_push)
        else $error("result buffer written while full");
`endif

endmodule
